>>> hdl/pop_pkg.sv
// Shared constants, types and helper functions for the perpendicular offset pair block.
package pop_pkg;

  localparam int COORD_W    = 32;            // coordinate and offset field width
  localparam int MAG_W      = COORD_W + 1;   // magnitude of an endpoint difference
  localparam int NORM_W     = 31;            // block-normalized magnitude
  localparam int ROOT_W     = 32;            // square roots and quotients
  localparam int RAD_W      = 64;            // radicands and dividends
  localparam int GAP_W      = 31;
  localparam int MINLEN_W   = 16;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int NORM_STEPS = 6;             // left shifts of 32, 16, 8, 4, 2, 1
  localparam int SQRT_STAGES = ROOT_W;       // one root bit per stage
  localparam int DIV_STAGES  = ROOT_W;       // one quotient bit per stage
  localparam int SQ_W   = 2 * NORM_W;
  localparam int PROD_W = GAP_W + ROOT_W;

  localparam logic [COORD_W-1:0] SAT_HALF = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_SCALE  = 1'b0,
    CFG_MIN_LENGTH = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [NORM_W-1:0] norm_t;
  typedef logic [2:0][NORM_W-1:0] norm_vec_t;

  typedef struct packed {
    axis_t      k;       // axis with the smallest magnitude
    logic [2:0] ng;      // sign of each difference, bit per axis
    logic       degen;   // segment too short
  } pop_tag_t;

  function automatic axis_t axis_next(input axis_t a);
    axis_t r;
    case (a)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_Z;
      default: r = AXIS_X;
    endcase
    return r;
  endfunction

  // Apply a sign to a magnitude and clamp to the signed coordinate range.
  function automatic logic [COORD_W-1:0] sat_emit(input logic [ROOT_W-1:0] mag,
                                                  input logic neg);
    logic [COORD_W-1:0] lim;
    if (neg) begin
      lim = (mag > SAT_HALF) ? SAT_HALF : mag;
      return COORD_W'(0) - lim;
    end else begin
      return (mag > SAT_HALF - 1'b1) ? SAT_HALF - 1'b1 : mag;
    end
  endfunction

endpackage

>>> hdl/pop_front.sv
// Front end: endpoint differences, length test, axis choice and block normalization.
module pop_front import pop_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [COORD_W-1:0]  start_x,
  input  logic signed [COORD_W-1:0]  start_y,
  input  logic signed [COORD_W-1:0]  start_z,
  input  logic signed [COORD_W-1:0]  end_x,
  input  logic signed [COORD_W-1:0]  end_y,
  input  logic signed [COORD_W-1:0]  end_z,
  input  logic [MINLEN_W-1:0]        min_length,
  output logic                       out_valid,
  output norm_vec_t                  out_mag,
  output pop_tag_t                   out_tag
);

  logic signed [COORD_W-1:0] pt_s [3];
  logic signed [COORD_W-1:0] pt_e [3];
  logic signed [MAG_W-1:0]   diff [3];

  mag_t       d0_mag [3];
  logic [2:0] d0_ng;
  logic       d0_v;

  mag_t                    s1_mag [3];
  logic [2:0]              s1_ng;
  axis_t                   s1_k;
  logic                    s1_big;
  logic [2*MINLEN_W-1:0]   s1_sq [3];
  logic [2*MINLEN_W-1:0]   s1_lim2;
  mag_t                    s1_mx;
  logic                    s1_v;

  axis_t                   k_sel;
  logic                    big_sel;
  mag_t                    mx_sel;
  logic [2*MINLEN_W+1:0]   sq_sum;

  mag_t            cur_mag [NORM_STEPS][3];
  mag_t            cur_mx  [NORM_STEPS];
  pop_tag_t        cur_tag [NORM_STEPS];
  logic            cur_v   [NORM_STEPS];
  mag_t            nm_mag  [NORM_STEPS][3];
  mag_t            nm_mx   [NORM_STEPS];
  pop_tag_t        nm_tag  [NORM_STEPS];
  logic            nm_v    [NORM_STEPS];
  mag_t            st_mag  [NORM_STEPS][3];
  mag_t            st_mx   [NORM_STEPS];

  assign pt_s[0] = start_x;
  assign pt_s[1] = start_y;
  assign pt_s[2] = start_z;
  assign pt_e[0] = end_x;
  assign pt_e[1] = end_y;
  assign pt_e[2] = end_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = MAG_W'(pt_e[c]) - MAG_W'(pt_s[c]);
    end
  end

  // Axis choice, largest magnitude and the small-segment test terms.
  always_comb begin
    k_sel = AXIS_X;
    if (d0_mag[1] < d0_mag[0]) k_sel = AXIS_Y;
    if (d0_mag[2] < d0_mag[k_sel]) k_sel = AXIS_Z;
    big_sel = 1'b0;
    mx_sel  = '0;
    for (int c = 0; c < 3; c++) begin
      if (d0_mag[c] > MAG_W'(min_length)) big_sel = 1'b1;
      if (d0_mag[c] > mx_sel) mx_sel = d0_mag[c];
    end
  end

  assign sq_sum = (2*MINLEN_W+2)'(s1_sq[0]) + (2*MINLEN_W+2)'(s1_sq[1])
                + (2*MINLEN_W+2)'(s1_sq[2]);

  // Each normalizing step shifts left when the top bits of the largest magnitude are zero.
  always_comb begin
    cur_mag[0] = s1_mag;
    cur_mx[0]  = s1_mx;
    cur_v[0]   = s1_v;
    cur_tag[0].k     = s1_k;
    cur_tag[0].ng    = s1_ng;
    cur_tag[0].degen = !s1_big && (sq_sum <= (2*MINLEN_W+2)'(s1_lim2));
    for (int s = 1; s < NORM_STEPS; s++) begin
      cur_mag[s] = nm_mag[s-1];
      cur_mx[s]  = nm_mx[s-1];
      cur_tag[s] = nm_tag[s-1];
      cur_v[s]   = nm_v[s-1];
    end
    for (int s = 0; s < NORM_STEPS; s++) begin
      if ((cur_mx[s] >> (MAG_W - (32 >> s))) == '0) begin
        st_mx[s] = cur_mx[s] << (32 >> s);
        for (int c = 0; c < 3; c++) st_mag[s][c] = cur_mag[s][c] << (32 >> s);
      end else begin
        st_mx[s] = cur_mx[s];
        for (int c = 0; c < 3; c++) st_mag[s][c] = cur_mag[s][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_v <= 1'b0;
      s1_v <= 1'b0;
      for (int s = 0; s < NORM_STEPS; s++) nm_v[s] <= 1'b0;
    end else if (en) begin
      d0_v <= in_valid;
      s1_v <= d0_v;
      for (int s = 0; s < NORM_STEPS; s++) nm_v[s] <= cur_v[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        d0_ng[c]  <= diff[c][MAG_W-1];
        d0_mag[c] <= diff[c][MAG_W-1] ? MAG_W'(0) - MAG_W'(diff[c]) : MAG_W'(diff[c]);
        s1_mag[c] <= d0_mag[c];
        s1_sq[c]  <= d0_mag[c][MINLEN_W-1:0] * d0_mag[c][MINLEN_W-1:0];
      end
      s1_ng   <= d0_ng;
      s1_k    <= k_sel;
      s1_big  <= big_sel;
      s1_mx   <= mx_sel;
      s1_lim2 <= min_length * min_length;
      for (int s = 0; s < NORM_STEPS; s++) begin
        nm_mag[s] <= st_mag[s];
        nm_mx[s]  <= st_mx[s];
        nm_tag[s] <= cur_tag[s];
      end
    end
  end

  // The largest magnitude now sits in [2^32, 2^33); dropping two bits lands it in [2^30, 2^31).
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      out_mag[c] = nm_mag[NORM_STEPS-1][c][MAG_W-1 -: NORM_W];
    end
  end
  assign out_tag   = nm_tag[NORM_STEPS-1];
  assign out_valid = nm_v[NORM_STEPS-1];

endmodule

>>> hdl/pop_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module pop_sqrt import pop_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0] v_q  [SQRT_STAGES];
  logic [RAD_W-1:0] r_q  [SQRT_STAGES];
  logic [RAD_W-1:0] v_in [SQRT_STAGES];
  logic [RAD_W-1:0] r_in [SQRT_STAGES];
  logic [RAD_W-1:0] v_nx [SQRT_STAGES];
  logic [RAD_W-1:0] r_nx [SQRT_STAGES];
  logic [RAD_W-1:0] bitv [SQRT_STAGES];
  logic [RAD_W:0]   trial [SQRT_STAGES];

  always_comb begin
    v_in[0] = radicand;
    r_in[0] = '0;
    for (int n = 1; n < SQRT_STAGES; n++) begin
      v_in[n] = v_q[n-1];
      r_in[n] = r_q[n-1];
    end
    for (int n = 0; n < SQRT_STAGES; n++) begin
      bitv[n]  = RAD_W'(1) << (RAD_W - 2 - 2*n);
      trial[n] = {1'b0, r_in[n]} + {1'b0, bitv[n]};
      if ({1'b0, v_in[n]} >= trial[n]) begin
        v_nx[n] = v_in[n] - trial[n][RAD_W-1:0];
        r_nx[n] = (r_in[n] >> 1) + bitv[n];
      end else begin
        v_nx[n] = v_in[n];
        r_nx[n] = r_in[n] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < SQRT_STAGES; n++) begin
        v_q[n] <= v_nx[n];
        r_q[n] <= r_nx[n];
      end
    end
  end

  assign root = r_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

>>> hdl/pop_div.sv
// Pipelined restoring divider, one quotient bit per stage; the quotient must fit ROOT_W bits.
module pop_div import pop_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [ROOT_W-1:0] quo
);

  logic [ROOT_W-1:0] rem_q [DIV_STAGES];
  logic [ROOT_W-1:0] low_q [DIV_STAGES];
  logic [ROOT_W-1:0] quo_q [DIV_STAGES];
  logic [ROOT_W-1:0] den_q [DIV_STAGES];
  logic [ROOT_W-1:0] rem_in [DIV_STAGES];
  logic [ROOT_W-1:0] low_in [DIV_STAGES];
  logic [ROOT_W-1:0] quo_in [DIV_STAGES];
  logic [ROOT_W-1:0] den_in [DIV_STAGES];
  logic [ROOT_W:0]   part  [DIV_STAGES];
  logic              ge    [DIV_STAGES];
  logic [ROOT_W:0]   diffv [DIV_STAGES];

  always_comb begin
    rem_in[0] = num[RAD_W-1:ROOT_W];
    low_in[0] = num[ROOT_W-1:0];
    quo_in[0] = '0;
    den_in[0] = den;
    for (int n = 1; n < DIV_STAGES; n++) begin
      rem_in[n] = rem_q[n-1];
      low_in[n] = low_q[n-1];
      quo_in[n] = quo_q[n-1];
      den_in[n] = den_q[n-1];
    end
    for (int n = 0; n < DIV_STAGES; n++) begin
      part[n]  = {rem_in[n], low_in[n][ROOT_W-1]};
      ge[n]    = part[n] >= {1'b0, den_in[n]};
      diffv[n] = part[n] - {1'b0, den_in[n]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < DIV_STAGES; n++) begin
        rem_q[n] <= ge[n] ? diffv[n][ROOT_W-1:0] : part[n][ROOT_W-1:0];
        low_q[n] <= low_in[n] << 1;
        quo_q[n] <= {quo_in[n][ROOT_W-2:0], ge[n]};
        den_q[n] <= den_in[n];
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

>>> hdl/perpendicular_offset_pair.sv
// Throughput: one item per cycle while not held; every stage advances together.
// The pipeline holds only when the output register is full and out_ready is low.
// Most depth is in two 32-stage square root units and two chained banks of 32-stage dividers.
// Reset (synchronous, active high) clears every valid bit and loads gap_scale = 1.0 and
// min_length = 1; there is no clearing pass.
module perpendicular_offset_pair import pop_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] start_z,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic signed [COORD_W-1:0] end_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] first_x,
  output logic signed [COORD_W-1:0] first_y,
  output logic signed [COORD_W-1:0] first_z,
  output logic signed [COORD_W-1:0] second_x,
  output logic signed [COORD_W-1:0] second_y,
  output logic signed [COORD_W-1:0] second_z,
  output logic                      degenerate,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // Side data that rides alongside the square root units.
  typedef struct packed {
    pop_tag_t tag;
    norm_t    ai;
    norm_t    aj;
    norm_t    ak;
  } sq_side_t;

  // Side data that rides alongside the first divider bank.
  typedef struct packed {
    pop_tag_t          tag;
    logic [ROOT_W-1:0] len;
  } d1_side_t;

  // Side data that rides alongside the second divider bank.
  typedef struct packed {
    pop_tag_t          tag;
    logic [ROOT_W-1:0] fk;
    logic [ROOT_W-1:0] si;
    logic [ROOT_W-1:0] sj;
  } d2_side_t;

  logic en;

  logic [GAP_W-1:0]    gap_scale;
  logic [MINLEN_W-1:0] min_length;

  // Front end outputs.
  logic      fr_valid;
  norm_vec_t fr_mag;
  pop_tag_t  fr_tag;

  axis_t fr_i, fr_j;

  // Squares of the normalized magnitudes, routed by axis role.
  logic            p1_v;
  pop_tag_t        p1_tag;
  norm_t           p1_ai, p1_aj, p1_ak;
  logic [SQ_W-1:0] p1_sqi, p1_sqj, p1_sqk;

  // Radicands for the off-axis length and the full length.
  logic             p2_v;
  pop_tag_t         p2_tag;
  norm_t            p2_ai, p2_aj, p2_ak;
  logic [RAD_W-1:0] p2_ss, p2_ll, ss_sum;

  logic [ROOT_W-1:0] root_s, root_l;
  sq_side_t          sq_side [SQRT_STAGES];
  logic              sq_v    [SQRT_STAGES];

  // Products feeding the first divider bank.
  logic              p3_v;
  pop_tag_t          p3_tag;
  logic [ROOT_W-1:0] p3_s, p3_l;
  logic [PROD_W-1:0] p3_fk, p3_si, p3_sj;
  logic [SQ_W-1:0]   p3_qi, p3_qj;

  // Dividends with the half-divisor added for round-half-up.
  logic              p4_v;
  pop_tag_t          p4_tag;
  logic [ROOT_W-1:0] p4_s, p4_l;
  logic [RAD_W-1:0]  p4_fk, p4_qi, p4_qj, p4_si, p4_sj;

  logic [ROOT_W-1:0] q_fk, q_qi, q_qj, q_si, q_sj;
  d1_side_t          d1_side [DIV_STAGES];
  logic              d1_v    [DIV_STAGES];

  // Gap times the projected components.
  logic              p5_v;
  pop_tag_t          p5_tag;
  logic [ROOT_W-1:0] p5_l, p5_fk, p5_si, p5_sj;
  logic [PROD_W-1:0] p5_fi, p5_fj;

  logic              p6_v;
  pop_tag_t          p6_tag;
  logic [ROOT_W-1:0] p6_l, p6_fk, p6_si, p6_sj;
  logic [RAD_W-1:0]  p6_fi, p6_fj;

  logic [ROOT_W-1:0] q_fi, q_fj;
  d2_side_t          d2_side [DIV_STAGES];
  logic              d2_v    [DIV_STAGES];

  // Final placement by axis role.
  d2_side_t                   fin;
  axis_t                      fin_i, fin_j;
  logic [2:0][COORD_W-1:0]    first_nx, second_nx;

  // The whole pipeline moves as one; it holds only while a result waits at the output.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers; write only while the block is idle (the block does not check).
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_scale  <= GAP_W'(65536);
      min_length <= MINLEN_W'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_GAP_SCALE:  gap_scale  <= cfg_data[GAP_W-1:0];
        CFG_MIN_LENGTH: min_length <= cfg_data[MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  pop_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .start_z   (start_z),
    .end_x     (end_x),
    .end_y     (end_y),
    .end_z     (end_z),
    .min_length(min_length),
    .out_valid (fr_valid),
    .out_mag   (fr_mag),
    .out_tag   (fr_tag)
  );

  // The two axes other than the chosen one, in cyclic order after it.
  assign fr_i = axis_next(fr_tag.k);
  assign fr_j = axis_next(fr_i);

  assign ss_sum = RAD_W'(p1_sqi) + RAD_W'(p1_sqj);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_tag <= fr_tag;
      p1_ak  <= fr_mag[fr_tag.k];
      p1_ai  <= fr_mag[fr_i];
      p1_aj  <= fr_mag[fr_j];
      p1_sqk <= SQ_W'(fr_mag[fr_tag.k]) * SQ_W'(fr_mag[fr_tag.k]);
      p1_sqi <= SQ_W'(fr_mag[fr_i]) * SQ_W'(fr_mag[fr_i]);
      p1_sqj <= SQ_W'(fr_mag[fr_j]) * SQ_W'(fr_mag[fr_j]);

      p2_tag <= p1_tag;
      p2_ai  <= p1_ai;
      p2_aj  <= p1_aj;
      p2_ak  <= p1_ak;
      p2_ss  <= ss_sum;
      p2_ll  <= ss_sum + RAD_W'(p1_sqk);
    end
  end

  pop_sqrt u_sqrt_s (.clk(clk), .en(en), .radicand(p2_ss), .root(root_s));
  pop_sqrt u_sqrt_l (.clk(clk), .en(en), .radicand(p2_ll), .root(root_l));

  // After the roots: L >= s >= 2^30 for every real segment, so no divisor is zero.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= '{tag: p2_tag, ai: p2_ai, aj: p2_aj, ak: p2_ak};
      for (int n = 1; n < SQRT_STAGES; n++) sq_side[n] <= sq_side[n-1];

      p3_tag <= sq_side[SQRT_STAGES-1].tag;
      p3_s   <= root_s;
      p3_l   <= root_l;
      p3_fk  <= PROD_W'(gap_scale) * PROD_W'(root_s);
      p3_qi  <= SQ_W'(sq_side[SQRT_STAGES-1].ak) * SQ_W'(sq_side[SQRT_STAGES-1].ai);
      p3_qj  <= SQ_W'(sq_side[SQRT_STAGES-1].ak) * SQ_W'(sq_side[SQRT_STAGES-1].aj);
      p3_si  <= PROD_W'(gap_scale) * PROD_W'(sq_side[SQRT_STAGES-1].aj);
      p3_sj  <= PROD_W'(gap_scale) * PROD_W'(sq_side[SQRT_STAGES-1].ai);

      p4_tag <= p3_tag;
      p4_s   <= p3_s;
      p4_l   <= p3_l;
      p4_fk  <= RAD_W'(p3_fk) + RAD_W'(p3_l >> 1);
      p4_qi  <= RAD_W'(p3_qi) + RAD_W'(p3_s >> 1);
      p4_qj  <= RAD_W'(p3_qj) + RAD_W'(p3_s >> 1);
      p4_si  <= RAD_W'(p3_si) + RAD_W'(p3_s >> 1);
      p4_sj  <= RAD_W'(p3_sj) + RAD_W'(p3_s >> 1);
    end
  end

  pop_div u_div_fk (.clk(clk), .en(en), .num(p4_fk), .den(p4_l), .quo(q_fk));
  pop_div u_div_qi (.clk(clk), .en(en), .num(p4_qi), .den(p4_s), .quo(q_qi));
  pop_div u_div_qj (.clk(clk), .en(en), .num(p4_qj), .den(p4_s), .quo(q_qj));
  pop_div u_div_si (.clk(clk), .en(en), .num(p4_si), .den(p4_s), .quo(q_si));
  pop_div u_div_sj (.clk(clk), .en(en), .num(p4_sj), .den(p4_s), .quo(q_sj));

  always_ff @(posedge clk) begin
    if (en) begin
      d1_side[0] <= '{tag: p4_tag, len: p4_l};
      for (int n = 1; n < DIV_STAGES; n++) d1_side[n] <= d1_side[n-1];

      p5_tag <= d1_side[DIV_STAGES-1].tag;
      p5_l   <= d1_side[DIV_STAGES-1].len;
      p5_fk  <= q_fk;
      p5_si  <= q_si;
      p5_sj  <= q_sj;
      p5_fi  <= PROD_W'(gap_scale) * PROD_W'(q_qi);
      p5_fj  <= PROD_W'(gap_scale) * PROD_W'(q_qj);

      p6_tag <= p5_tag;
      p6_l   <= p5_l;
      p6_fk  <= p5_fk;
      p6_si  <= p5_si;
      p6_sj  <= p5_sj;
      p6_fi  <= RAD_W'(p5_fi) + RAD_W'(p5_l >> 1);
      p6_fj  <= RAD_W'(p5_fj) + RAD_W'(p5_l >> 1);
    end
  end

  pop_div u_div_fi (.clk(clk), .en(en), .num(p6_fi), .den(p6_l), .quo(q_fi));
  pop_div u_div_fj (.clk(clk), .en(en), .num(p6_fj), .den(p6_l), .quo(q_fj));

  always_ff @(posedge clk) begin
    if (en) begin
      d2_side[0] <= '{tag: p6_tag, fk: p6_fk, si: p6_si, sj: p6_sj};
      for (int n = 1; n < DIV_STAGES; n++) d2_side[n] <= d2_side[n-1];
    end
  end

  // Valid bits travel in step with the data through every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
      p6_v <= 1'b0;
      for (int n = 0; n < SQRT_STAGES; n++) sq_v[n] <= 1'b0;
      for (int n = 0; n < DIV_STAGES; n++) begin
        d1_v[n] <= 1'b0;
        d2_v[n] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      p1_v <= fr_valid;
      p2_v <= p1_v;
      sq_v[0] <= p2_v;
      for (int n = 1; n < SQRT_STAGES; n++) sq_v[n] <= sq_v[n-1];
      p3_v <= sq_v[SQRT_STAGES-1];
      p4_v <= p3_v;
      d1_v[0] <= p4_v;
      for (int n = 1; n < DIV_STAGES; n++) d1_v[n] <= d1_v[n-1];
      p5_v <= d1_v[DIV_STAGES-1];
      p6_v <= p5_v;
      d2_v[0] <= p6_v;
      for (int n = 1; n < DIV_STAGES; n++) d2_v[n] <= d2_v[n-1];
      out_valid <= d2_v[DIV_STAGES-1];
    end
  end

  // Signs and placement. The first offset is positive along the chosen axis and its other
  // components take the opposite sign of that axis times the component. The second offset
  // is zero along the chosen axis.
  assign fin   = d2_side[DIV_STAGES-1];
  assign fin_i = axis_next(fin.tag.k);
  assign fin_j = axis_next(fin_i);

  always_comb begin
    first_nx  = '0;
    second_nx = '0;
    if (!fin.tag.degen) begin
      first_nx[fin.tag.k] = sat_emit(fin.fk, 1'b0);
      first_nx[fin_i] = sat_emit(q_fi, fin.tag.ng[fin.tag.k] == fin.tag.ng[fin_i]);
      first_nx[fin_j] = sat_emit(q_fj, fin.tag.ng[fin.tag.k] == fin.tag.ng[fin_j]);
      second_nx[fin_i] = sat_emit(fin.si, fin.tag.ng[fin_j]);
      second_nx[fin_j] = sat_emit(fin.sj, !fin.tag.ng[fin_i]);
    end
  end

  // Output register: holds its item until out_ready.
  always_ff @(posedge clk) begin
    if (en) begin
      first_x    <= first_nx[AXIS_X];
      first_y    <= first_nx[AXIS_Y];
      first_z    <= first_nx[AXIS_Z];
      second_x   <= second_nx[AXIS_X];
      second_y   <= second_nx[AXIS_Y];
      second_z   <= second_nx[AXIS_Z];
      degenerate <= fin.tag.degen;
    end
  end

endmodule

>>> hdl/pop_checker.sv
// Port-level checker for the perpendicular offset pair block, bound to the top level.
module pop_checker import pop_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] first_x,
  input logic signed [COORD_W-1:0] first_y,
  input logic signed [COORD_W-1:0] first_z,
  input logic signed [COORD_W-1:0] second_x,
  input logic signed [COORD_W-1:0] second_y,
  input logic signed [COORD_W-1:0] second_z,
  input logic                      degenerate
);

  // first_x, second_z and degenerate of a waiting result stay put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_x) && $stable(second_z)
      && $stable(degenerate))
    else $error("result item changed while stalled");

  // Input is only held back while a result waits.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A short segment gives zero offsets.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> first_x == '0 && first_y == '0 && first_z == '0
      && second_x == '0 && second_y == '0 && second_z == '0)
    else $error("degenerate item with nonzero offsets");

  // The second offset has no component along the chosen axis.
  a_second_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> second_x == '0 || second_y == '0 || second_z == '0)
    else $error("second offset has no zero component");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind perpendicular_offset_pair pop_checker u_pop_checker (.*);
